// File: design/rwgm_pkg.sv
// Shared types and constants for the rotated window grid merge block.
`default_nettype none
package rwgm_pkg;

	// Field widths of the stream items
	localparam int ADDR_W  = 16;
	localparam int CELL_W  = 8;
	localparam int LOC_W   = 6;
	localparam int FUNC_W  = 2;
	localparam int IN_TDATA_W = 40;

	// Datapath widths
	localparam int TRIG_W  = 16;   // Q2.14 cosine and sine
	localparam int SHIFT_W = 24;   // Q16.8 offsets in cells
	localparam int DELTA_W = 9;    // window offset i - half
	localparam int PROD_W  = TRIG_W + DELTA_W;
	localparam int ACC_W   = 32;   // Q.14 coordinate sum
	localparam int FRAC_W  = 14;
	localparam int CELLC_W = ACC_W - FRAC_W;
	localparam int SHIFT_ALIGN = 6; // Q.8 to Q.14

	// Configuration register map
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;
	localparam int REGS_PER_GRID = 4;
	localparam int REG_COS       = 0;
	localparam int REG_SIN       = 1;
	localparam int REG_SHX       = 2;
	localparam int REG_SHY       = 3;
	localparam int NUM_GRIDS     = 2;

	localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

	// Occupancy codes
	localparam logic signed [CELL_W-1:0] OCC_VAL  = 8'sd100;
	localparam logic signed [CELL_W-1:0] FREE_VAL = 8'sd0;
	localparam logic signed [CELL_W-1:0] UNK_VAL  = -8'sd1;

	typedef enum logic [FUNC_W-1:0] {
		FN_WR_ONE = 2'd0,
		FN_WR_TWO = 2'd1,
		FN_QUERY  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_IDX,
		ST_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [NUM_GRIDS-1:0] wr_grid;
		logic mul_en;
		logic sum_en;
		logic div_en;
		logic idx_en;
		logic rd_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// File: design/rwgm_ctrl.sv
// Controller: accepts items and steps the datapath through one query.
`default_nettype none
module rwgm_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic [rwgm_pkg::FUNC_W-1:0] s_func,
	output logic                          s_tready,
	input  wire rwgm_pkg::status_t        status,
	output rwgm_pkg::cmd_t                cmd
);
	import rwgm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (s_func)
						FN_WR_ONE: cmd.wr_grid[0] = 1'b1;
						FN_WR_TWO: cmd.wr_grid[1] = 1'b1;
						FN_QUERY: begin
							cmd.mul_en = 1'b1;
							state_d    = ST_SUM;
						end
						default: ; // unused code, item dropped
					endcase
				end
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_d    = ST_IDX;
			end
			ST_IDX: begin
				cmd.idx_en = 1'b1;
				state_d    = ST_RD;
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: design/rwgm_dp.sv
// Datapath: config registers, grid stores, transform pipeline, merge and output register.
`default_nettype none
module rwgm_dp #(
	parameter int LOCAL_SIDE = 64,
	parameter int GRID_COLS  = 256,
	parameter int GRID_ROWS  = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rwgm_pkg::cmd_t                 cmd,
	output rwgm_pkg::status_t                   status,
	input  wire logic [rwgm_pkg::ADDR_W-1:0]    grid_address,
	input  wire logic [rwgm_pkg::CELL_W-1:0]    grid_value,
	input  wire logic [rwgm_pkg::LOC_W-1:0]     local_col,
	input  wire logic [rwgm_pkg::LOC_W-1:0]     local_row,
	input  wire logic                           cfg_we,
	input  wire logic [rwgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rwgm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [rwgm_pkg::CELL_W-1:0]         m_tdata,
	output logic                                m_tuser
);
	import rwgm_pkg::*;

	localparam int HALF      = LOCAL_SIDE / 2;
	localparam int STORE_DEP = 2 ** ADDR_W;

	logic signed [DELTA_W-1:0] dx, dy;
	logic signed [CELL_W-1:0]  cell_v [NUM_GRIDS];
	logic [NUM_GRIDS-1:0]      loaded_q;
	logic                      occ, unk, both_loaded;
	logic signed [CELL_W-1:0]  merged;
	logic                      m_valid_q;
	logic [CELL_W-1:0]         m_data_q;
	logic                      m_user_q;

	assign dx = $signed({{(DELTA_W-LOC_W){1'b0}}, local_col}) - $signed(DELTA_W'(HALF));
	assign dy = $signed({{(DELTA_W-LOC_W){1'b0}}, local_row}) - $signed(DELTA_W'(HALF));

	for (genvar g = 0; g < NUM_GRIDS; g++) begin : g_grid
		logic signed [TRIG_W-1:0]  cos_q, sin_q;
		logic signed [SHIFT_W-1:0] shx_q, shy_q;
		logic signed [PROD_W-1:0]  p_cx_s1, p_sy_s1, p_sx_s1, p_cy_s1;
		logic signed [ACC_W-1:0]   ax_s2, ay_s2;
		logic [ACC_W-1:0]          ax_b, ay_b;
		logic [CELLC_W-1:0]        gx_s3, gy_s3;
		logic                      in_s4, in_s5;
		logic [ADDR_W-1:0]         idx_s4;
		logic [CELL_W-1:0]         rd_s5;
		logic [CELL_W-1:0]         store [STORE_DEP];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cos_q <= COS_RESET;
				sin_q <= '0;
				shx_q <= '0;
				shy_q <= '0;
			end else if (cfg_we) begin
				if (cfg_index == CFG_IDX_W'(g * REGS_PER_GRID + REG_COS))
					cos_q <= $signed(cfg_data[TRIG_W-1:0]);
				if (cfg_index == CFG_IDX_W'(g * REGS_PER_GRID + REG_SIN))
					sin_q <= $signed(cfg_data[TRIG_W-1:0]);
				if (cfg_index == CFG_IDX_W'(g * REGS_PER_GRID + REG_SHX))
					shx_q <= $signed(cfg_data);
				if (cfg_index == CFG_IDX_W'(g * REGS_PER_GRID + REG_SHY))
					shy_q <= $signed(cfg_data);
			end
		end

		// truncation toward zero: bias negative sums before the shift
		assign ax_b = ax_s2 + {{CELLC_W{1'b0}}, {FRAC_W{ax_s2[ACC_W-1]}}};
		assign ay_b = ay_s2 + {{CELLC_W{1'b0}}, {FRAC_W{ay_s2[ACC_W-1]}}};

		always_ff @(posedge clk) begin
			if (cmd.mul_en) begin
				p_cx_s1 <= PROD_W'(cos_q) * PROD_W'(dx);
				p_sy_s1 <= PROD_W'(sin_q) * PROD_W'(dy);
				p_sx_s1 <= PROD_W'(sin_q) * PROD_W'(dx);
				p_cy_s1 <= PROD_W'(cos_q) * PROD_W'(dy);
			end
			if (cmd.sum_en) begin
				ax_s2 <= ACC_W'(p_cx_s1) - ACC_W'(p_sy_s1) + (ACC_W'(shx_q) <<< SHIFT_ALIGN);
				ay_s2 <= ACC_W'(p_sx_s1) + ACC_W'(p_cy_s1) + (ACC_W'(shy_q) <<< SHIFT_ALIGN);
			end
			if (cmd.div_en) begin
				gx_s3 <= ax_b[ACC_W-1:FRAC_W];
				gy_s3 <= ay_b[ACC_W-1:FRAC_W];
			end
			if (cmd.idx_en) begin
				in_s4 <= !gx_s3[CELLC_W-1] && (gx_s3[CELLC_W-2:0] < (CELLC_W-1)'(GRID_COLS))
					&& !gy_s3[CELLC_W-1] && (gy_s3[CELLC_W-2:0] < (CELLC_W-1)'(GRID_ROWS));
				// linear index wraps modulo the store depth
				idx_s4 <= gy_s3[ADDR_W-1:0] * ADDR_W'(GRID_COLS) + gx_s3[ADDR_W-1:0];
			end
			if (cmd.rd_en) begin
				in_s5 <= in_s4;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.wr_grid[g])
				store[grid_address] <= grid_value;
			if (cmd.rd_en)
				rd_s5 <= store[idx_s4];
		end

		assign cell_v[g] = in_s5 ? $signed(rd_s5) : UNK_VAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else begin
			loaded_q <= loaded_q | cmd.wr_grid;
		end
	end

	assign both_loaded = &loaded_q;
	assign occ = (cell_v[0] > FREE_VAL) || (cell_v[1] > FREE_VAL);
	assign unk = (cell_v[0] == UNK_VAL) || (cell_v[1] == UNK_VAL);

	always_comb begin
		priority if (!both_loaded) merged = UNK_VAL;
		else if (occ)              merged = OCC_VAL;
		else if (unk)              merged = UNK_VAL;
		else                       merged = FREE_VAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= merged;
			m_user_q <= both_loaded;
		end
	end

	assign status.out_busy = m_valid_q && !m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
`default_nettype wire

// File: design/rotated_window_grid_merge_top.sv
// Top level of the rotated window grid merge block.
`default_nettype none
// Holds two occupancy grids of 65536 8-bit cells each, written one cell per item,
// and answers window queries by rotating and shifting the window offset into each
// grid, reading both cells and merging them (100 occupied, 0 free, -1 unknown).
// Cell writes are taken one per cycle while no query is in progress. The products
// are taken at the accept edge. Sum, truncate, index, store read and output load
// then follow in that order, and the next item is taken in the cycle after the
// output load. If the previous result is still waiting at the load step, the
// query holds there until the receiver takes that result.
// The output register lets the next item in while a result waits.
// Grid stores have no reset; reading a never-written cell gives an arbitrary value.
module rotated_window_grid_merge_top #(
	parameter int LOCAL_SIDE = 64,
	parameter int GRID_COLS  = 256,
	parameter int GRID_ROWS  = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [15:0] grid_address, [23:16] grid_value, [29:24] local_col, [35:30] local_row
	input  wire logic [rwgm_pkg::IN_TDATA_W-1:0] s_tdata,
	// [1:0] func
	input  wire logic [rwgm_pkg::FUNC_W-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [7:0] merged_value
	output logic [rwgm_pkg::CELL_W-1:0]          m_tdata,
	// [0] ready_res
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rwgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rwgm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rwgm_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	rwgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rwgm_dp #(
		.LOCAL_SIDE (LOCAL_SIDE),
		.GRID_COLS  (GRID_COLS),
		.GRID_ROWS  (GRID_ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.grid_address (s_tdata[15:0]),
		.grid_value   (s_tdata[23:16]),
		.local_col    (s_tdata[29:24]),
		.local_row    (s_tdata[35:30]),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
`default_nettype wire
